// ===== src/mpq_pkg.sv =====
// shared types and constants of the min-first priority queue
// no dependencies; imported by mpq_ctrl, mpq_dp and min_priority_queue
package mpq_pkg;

  localparam int PRIO_W        = 16;
  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic       insert_wr;   // write the beat at the tail, count up
    logic       set_result;  // latch res_code
    logic [1:0] res_code;
    logic       scan_start;  // pointer to entry zero
    logic       rd_issue;    // read entry at pointer, pointer up
    logic       compare_en;  // returning read competes for minimum
    logic       shift_start; // pointer to one past the minimum
    logic       shift_en;    // returning read moves down one place
    logic       dec_count;
    logic       out_load;
  } mpq_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic ptr_at_end;
    logic out_free;
  } mpq_stat_t;

endpackage

// ===== src/min_priority_queue.sv =====
// top level of the bounded min-first priority queue, stable on ties
// depends on mpq_pkg, mpq_ctrl and mpq_dp
//
//   channel  handshake             beat fields
//   in       in_valid / in_ready   kind, priority_req, payload
//   out      out_valid / out_ready status, out_priority, out_payload
//
// an insert, or a remove on an empty queue, sets its result as the beat is
// taken; a remove with n entries stored, minimum at position b, first scans
// all n entries and then shifts the entries after b down one place, both through
// the single read port of the entry memory, which they walk one entry a cycle.
// rst clears the fill count and control; entry memory needs no clearing.
// a result waiting on out_ready holds back the following one, not the next beat.
module min_priority_queue #(
  parameter int DEPTH = mpq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic signed [mpq_pkg::PRIO_W-1:0] priority_req,
  input  logic signed [mpq_pkg::DATA_W-1:0] payload,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [mpq_pkg::PRIO_W-1:0] out_priority,
  output logic signed [mpq_pkg::DATA_W-1:0] out_payload
);
  import mpq_pkg::*;

  mpq_cmd_t  cmd;
  mpq_stat_t stat;

  mpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .priority_req (priority_req),
    .payload      (payload),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_priority (out_priority),
    .out_payload  (out_payload)
  );

  // the block is never ready in the cycle after it takes a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("beat taken on consecutive cycles");

  a_no_read_past_count: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> !stat.ptr_at_end)
    else $error("entry read beyond fill count");

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert_wr |-> !stat.count_full)
    else $error("insert written into a full queue");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result overwrote an untaken result");

endmodule

// ===== src/mpq_ctrl.sv =====
// controller of the priority queue: sequences insert, scan and shift
// depends on mpq_pkg; drives mpq_dp through mpq_cmd_t
module mpq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              kind,
  output logic              in_ready,
  input  mpq_pkg::mpq_stat_t stat,
  output mpq_pkg::mpq_cmd_t  cmd
);
  import mpq_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_SCAN_END  = 3'd2;
  localparam logic [2:0] S_SHIFT     = 3'd3;
  localparam logic [2:0] S_SHIFT_END = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (kind == KIND_INSERT) begin
            cmd.set_result = 1'b1;
            if (stat.count_full) begin
              cmd.res_code = ST_FULL;
            end else begin
              cmd.res_code  = ST_INSERTED;
              cmd.insert_wr = 1'b1;
            end
            state_next = S_DONE;
          end else if (stat.count_zero) begin
            cmd.set_result = 1'b1;
            cmd.res_code   = ST_EMPTY;
            state_next     = S_DONE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.compare_en = 1'b1;
        if (stat.ptr_at_end) begin
          state_next = S_SCAN_END;
        end else begin
          cmd.rd_issue = 1'b1;
        end
      end
      S_SCAN_END: begin
        // minimum is settled, close the gap behind it
        cmd.shift_start = 1'b1;
        state_next      = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift_en = 1'b1;
        if (stat.ptr_at_end) begin
          state_next = S_SHIFT_END;
        end else begin
          cmd.rd_issue = 1'b1;
        end
      end
      S_SHIFT_END: begin
        cmd.dec_count  = 1'b1;
        cmd.set_result = 1'b1;
        cmd.res_code   = ST_REMOVED;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/mpq_dp.sv =====
// datapath of the priority queue: entry memory, pointer, minimum search,
// fill count and output register; depends on mpq_pkg
module mpq_dp #(
  parameter int DEPTH = mpq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mpq_pkg::mpq_cmd_t                 cmd,
  output mpq_pkg::mpq_stat_t                stat,
  input  logic signed [mpq_pkg::PRIO_W-1:0] priority_req,
  input  logic signed [mpq_pkg::DATA_W-1:0] payload,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [mpq_pkg::PRIO_W-1:0] out_priority,
  output logic signed [mpq_pkg::DATA_W-1:0] out_payload
);
  import mpq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [PRIO_W-1:0] prio_mem [DEPTH];
  logic [DATA_W-1:0] data_mem [DEPTH];

  logic [CW-1:0]     count;
  logic [CW-1:0]     ptr;
  logic              rd_vld;
  logic [AW-1:0]     rd_idx;
  logic [PRIO_W-1:0] rd_prio;
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0]     best_idx;
  logic [PRIO_W-1:0] best_prio;
  logic [DATA_W-1:0] best_data;
  logic [1:0]        res_code;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [PRIO_W-1:0] wr_prio;
  logic [DATA_W-1:0] wr_data;
  logic              take_best;

  assign stat.count_zero = (count == '0);
  assign stat.count_full = (count == CW'(DEPTH));
  assign stat.ptr_at_end = (ptr == count);
  assign stat.out_free   = !out_valid || out_ready;

  // one write port: tail insert or shift down by one
  always_comb begin
    if (cmd.insert_wr) begin
      wr_en   = 1'b1;
      wr_addr = count[AW-1:0];
      wr_prio = priority_req;
      wr_data = payload;
    end else begin
      wr_en   = cmd.shift_en && rd_vld;
      wr_addr = rd_idx - AW'(1);
      wr_prio = rd_prio;
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prio_mem[wr_addr] <= wr_prio;
      data_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_prio <= prio_mem[ptr[AW-1:0]];
      rd_data <= data_mem[ptr[AW-1:0]];
      rd_idx  <= ptr[AW-1:0];
    end
  end

  // strict compare keeps the earliest of equal priorities
  assign take_best = cmd.compare_en && rd_vld &&
                     ((rd_idx == '0) || ($signed(rd_prio) < $signed(best_prio)));

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_idx  <= rd_idx;
      best_prio <= rd_prio;
      best_data <= rd_data;
    end
    if (cmd.set_result) begin
      res_code <= cmd.res_code;
    end
    if (cmd.out_load) begin
      status <= res_code;
      if (res_code == ST_REMOVED) begin
        out_priority <= best_prio;
        out_payload  <= best_data;
      end else begin
        out_priority <= '0;
        out_payload  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_issue;
      if (cmd.insert_wr) begin
        count <= count + CW'(1);
      end else if (cmd.dec_count) begin
        count <= count - CW'(1);
      end
      if (cmd.scan_start) begin
        ptr <= '0;
      end else if (cmd.shift_start) begin
        ptr <= CW'(best_idx) + CW'(1);
      end else if (cmd.rd_issue) begin
        ptr <= ptr + CW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
